// ===== design/ibfp_pkg.sv =====
// ----------------------------------------------------------------------------
// ibfp_pkg
// Shared types and constants of the frame parser: request codes, the
// classified operation passed from front to back, and frame constants.
// ----------------------------------------------------------------------------
package ibfp_pkg;

  // request codes on the input channel
  localparam logic [1:0] REQ_BYTE    = 2'd0;
  localparam logic [1:0] REQ_GAP     = 2'd1;
  localparam logic [1:0] REQ_TIMEOUT = 2'd2;
  localparam logic [1:0] REQ_NONE    = 2'd3;

  localparam int unsigned CHANNEL_SLOTS_DEF = 16;
  localparam int unsigned QUEUE_DEPTH_DEF   = 4;

  localparam logic [7:0]  CMD_BYTE        = 8'h40;
  localparam logic [15:0] SUM_INIT        = 16'hFFFF;
  localparam logic [11:0] CHAN_MASK       = 12'hFFF;
  localparam logic [3:0]  FAIL_LIMIT_RST  = 4'd3;
  localparam logic [3:0]  FAIL_COUNT_MAX  = 4'd15;
  localparam logic [7:0]  MIN_LEN         = 8'd3;

  localparam logic KIND_CHANNEL = 1'b0;
  localparam logic KIND_FAIL    = 1'b1;

  typedef enum logic [1:0] {
    OP_BYTE,
    OP_GAP,
    OP_TIMEOUT
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
  } entry_t;

endpackage

// ===== design/ibfp_if.sv =====
// ----------------------------------------------------------------------------
// ibfp channel interfaces
// Valid/ready channels of the frame parser: input events, results and the
// fail limit configuration write.
// ----------------------------------------------------------------------------
interface ibfp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] data_byte;

  modport source (output valid, output req_type, output data_byte, input ready);
  modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

interface ibfp_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [4:0]  channel_index;
  logic [11:0] channel_value;
  logic [3:0]  fail_count;
  logic        stopped;
  logic        last;

  modport source (output valid, output kind, output channel_index, output channel_value,
                  output fail_count, output stopped, output last, input ready);
  modport sink   (input valid, input kind, input channel_index, input channel_value,
                  input fail_count, input stopped, input last, output ready);
endinterface

interface ibfp_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] fail_limit;

  modport source (output valid, output fail_limit, input ready);
  modport sink   (input valid, input fail_limit, output ready);
endinterface

// ===== design/ibfp_front.sv =====
// ----------------------------------------------------------------------------
// ibfp_front
// Accepts input events, drops the unused request code and registers each
// event as a classified operation for the queue.
// ----------------------------------------------------------------------------
module ibfp_front
  import ibfp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  ibfp_in_if.sink   in_i,
  output logic      push_o,
  output entry_t    push_entry_o,
  input  logic      push_ready_i
);

  logic   stg_v_q, stg_v_d;
  entry_t stg_q, stg_d;
  logic   accept;
  logic   keep;
  op_e    op;

  assign in_i.ready = !stg_v_q || push_ready_i;
  assign accept     = in_i.valid && in_i.ready;
  assign push_o       = stg_v_q;
  assign push_entry_o = stg_q;

  always_comb begin
    keep = 1'b1;
    op   = OP_BYTE;
    unique case (in_i.req_type)
      REQ_BYTE:    op = OP_BYTE;
      REQ_GAP:     op = OP_GAP;
      REQ_TIMEOUT: op = OP_TIMEOUT;
      REQ_NONE:    keep = 1'b0;
      default:     keep = 1'b0;
    endcase
  end

  always_comb begin
    stg_v_d = stg_v_q;
    stg_d   = stg_q;
    if (stg_v_q && push_ready_i) begin
      stg_v_d = 1'b0;
    end
    if (accept) begin
      stg_v_d    = keep;
      stg_d.op   = op;
      stg_d.data = in_i.data_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_v_q <= 1'b0;
    end else begin
      stg_v_q <= stg_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stg_q <= stg_d;
  end

endmodule

// ===== design/ibfp_queue.sv =====
// ----------------------------------------------------------------------------
// ibfp_queue
// Short FIFO of classified operations between the front and the back.
// ----------------------------------------------------------------------------
module ibfp_queue
  import ibfp_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_entry_i,
  output logic   push_ready_o,
  output logic   pop_valid_o,
  output entry_t pop_entry_o,
  input  logic   pop_i
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  entry_t             mem_q [DEPTH];
  logic [PTR_W-1:0]   wptr_q, rptr_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               do_push, do_pop;

  assign push_ready_o = (cnt_q != CNT_W'(DEPTH)) || pop_i;
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_entry_o  = mem_q[rptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= ptr_inc(wptr_q);
      end
      if (do_pop) begin
        rptr_q <= ptr_inc(rptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_entry_i;
    end
  end

endmodule

// ===== design/ibfp_back.sv =====
// ----------------------------------------------------------------------------
// ibfp_back
// Frame parser proper: runs the gap/length/body state machine, keeps the
// checksum and channel store, and drives the result register.
// ----------------------------------------------------------------------------
module ibfp_back
  import ibfp_pkg::*;
#(
  parameter int unsigned CHANNEL_SLOTS = CHANNEL_SLOTS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       op_valid_i,
  input  entry_t     op_entry_i,
  output logic       op_pop_o,
  ibfp_cfg_if.sink   cfg_i,
  ibfp_out_if.source out_o
);

  localparam int unsigned IDX_W = (CHANNEL_SLOTS > 1) ? $clog2(CHANNEL_SLOTS) : 1;

  typedef enum logic [1:0] {
    PH_GAP,
    PH_LEN,
    PH_BODY,
    PH_HALT
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [7:0]        len_q, len_d;
  logic [7:0]        pos_q, pos_d;
  logic [15:0]       sum_q, sum_d;
  logic [7:0]        held_q, held_d;
  logic              cmd_ok_q, cmd_ok_d;
  logic [3:0]        fails_q, fails_d;
  logic [3:0]        lim_q;
  logic              emit_q, emit_d;
  logic [IDX_W-1:0]  eidx_q, eidx_d;
  logic [11:0]       store_q [CHANNEL_SLOTS];

  logic              ov_q, ov_d;
  logic              okind_q, okind_d;
  logic [4:0]        oidx_q, oidx_d;
  logic [11:0]       oval_q, oval_d;
  logic [3:0]        ofc_q, ofc_d;
  logic              ostop_q, ostop_d;
  logic              olast_q, olast_d;

  logic              st_we;
  logic [IDX_W-1:0]  st_addr;
  logic [11:0]       st_data;

  logic              out_free;
  logic [7:0]        b;
  logic [8:0]        pos_ext;
  logic [6:0]        ch;
  logic [3:0]        lim_eff;
  logic [3:0]        fc_next;
  logic              fail;

  assign cfg_i.ready         = 1'b1;
  assign out_o.valid         = ov_q;
  assign out_o.kind          = okind_q;
  assign out_o.channel_index = oidx_q;
  assign out_o.channel_value = oval_q;
  assign out_o.fail_count    = ofc_q;
  assign out_o.stopped       = ostop_q;
  assign out_o.last          = olast_q;

  assign out_free = !ov_q || out_o.ready;
  assign b        = op_entry_i.data;
  assign pos_ext  = {1'b0, pos_q};
  assign ch       = 7'((pos_q - 8'd2) >> 1);
  assign lim_eff  = (lim_q == '0) ? 4'd1 : lim_q;
  assign fc_next  = (fails_q == FAIL_COUNT_MAX) ? FAIL_COUNT_MAX : fails_q + 4'd1;

  always_comb begin
    phase_d  = phase_q;
    len_d    = len_q;
    pos_d    = pos_q;
    sum_d    = sum_q;
    held_d   = held_q;
    cmd_ok_d = cmd_ok_q;
    fails_d  = fails_q;
    emit_d   = emit_q;
    eidx_d   = eidx_q;
    ov_d     = ov_q;
    okind_d  = okind_q;
    oidx_d   = oidx_q;
    oval_d   = oval_q;
    ofc_d    = ofc_q;
    ostop_d  = ostop_q;
    olast_d  = olast_q;
    st_we    = 1'b0;
    st_addr  = ch[IDX_W-1:0];
    st_data  = {b[3:0], held_q} & CHAN_MASK;
    op_pop_o = 1'b0;
    fail     = 1'b0;

    if (out_o.ready) begin
      ov_d = 1'b0;
    end

    if (emit_q) begin
      // dump the channel store, one slot per word
      if (out_free) begin
        ov_d    = 1'b1;
        okind_d = KIND_CHANNEL;
        oidx_d  = 5'(eidx_q);
        oval_d  = store_q[eidx_q];
        ofc_d   = '0;
        ostop_d = 1'b0;
        olast_d = (eidx_q == IDX_W'(CHANNEL_SLOTS - 1));
        if (olast_d) begin
          emit_d = 1'b0;
        end else begin
          eidx_d = eidx_q + IDX_W'(1);
        end
      end
    end else if (op_valid_i && out_free) begin
      op_pop_o = 1'b1;
      if (phase_q != PH_HALT) begin
        unique case (op_entry_i.op)
          OP_TIMEOUT: fail = 1'b1;
          OP_GAP: begin
            if (phase_q == PH_GAP) begin
              phase_d = PH_LEN;
            end
          end
          OP_BYTE: begin
            if (phase_q == PH_LEN) begin
              if (b <= MIN_LEN || b[0]) begin
                fail = 1'b1;
              end else begin
                len_d    = b;
                pos_d    = '0;
                sum_d    = SUM_INIT - {8'd0, b};
                held_d   = '0;
                cmd_ok_d = 1'b0;
                phase_d  = PH_BODY;
              end
            end else if (phase_q == PH_BODY) begin
              if (pos_ext + 9'd2 == {1'b0, len_q}) begin
                // checksum high byte closes the frame
                if (!cmd_ok_q || {b, held_q} != sum_q) begin
                  fail = 1'b1;
                end else begin
                  fails_d = '0;
                  phase_d = PH_LEN;
                  emit_d  = 1'b1;
                  eidx_d  = '0;
                end
              end else begin
                if (pos_q == '0) begin
                  cmd_ok_d = (b == CMD_BYTE);
                  sum_d    = sum_q - {8'd0, b};
                end else if (pos_ext + 9'd3 == {1'b0, len_q}) begin
                  held_d = b;
                end else if (pos_q[0]) begin
                  held_d = b;
                  sum_d  = sum_q - {8'd0, b};
                end else begin
                  st_we = cmd_ok_q && (ch < 7'(CHANNEL_SLOTS));
                  sum_d = sum_q - {8'd0, b};
                end
                pos_d = pos_q + 8'd1;
              end
            end
          end
          default: ;
        endcase
      end
      if (fail) begin
        fails_d = fc_next;
        phase_d = (fc_next >= lim_eff) ? PH_HALT : PH_GAP;
        ov_d    = 1'b1;
        okind_d = KIND_FAIL;
        oidx_d  = '0;
        oval_d  = '0;
        ofc_d   = fc_next;
        ostop_d = (fc_next >= lim_eff);
        olast_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_GAP;
      len_q    <= '0;
      pos_q    <= '0;
      sum_q    <= '0;
      held_q   <= '0;
      cmd_ok_q <= 1'b0;
      fails_q  <= '0;
      lim_q    <= FAIL_LIMIT_RST;
      emit_q   <= 1'b0;
      eidx_q   <= '0;
      ov_q     <= 1'b0;
      okind_q  <= 1'b0;
      oidx_q   <= '0;
      oval_q   <= '0;
      ofc_q    <= '0;
      ostop_q  <= 1'b0;
      olast_q  <= 1'b0;
      for (int i = 0; i < CHANNEL_SLOTS; i++) begin
        store_q[i] <= '0;
      end
    end else begin
      phase_q  <= phase_d;
      len_q    <= len_d;
      pos_q    <= pos_d;
      sum_q    <= sum_d;
      held_q   <= held_d;
      cmd_ok_q <= cmd_ok_d;
      fails_q  <= fails_d;
      emit_q   <= emit_d;
      eidx_q   <= eidx_d;
      ov_q     <= ov_d;
      okind_q  <= okind_d;
      oidx_q   <= oidx_d;
      oval_q   <= oval_d;
      ofc_q    <= ofc_d;
      ostop_q  <= ostop_d;
      olast_q  <= olast_d;
      if (cfg_i.valid) begin
        lim_q <= cfg_i.fail_limit;
      end
      if (st_we) begin
        store_q[st_addr] <= st_data;
      end
    end
  end

endmodule

// ===== design/ibus_frame_parser.sv =====
// ----------------------------------------------------------------------------
// ibus_frame_parser
// Receiver-side frame parser for a serial RC channel stream.
// ----------------------------------------------------------------------------
// Channels: in_i carries one event per word (byte, idle gap or timeout),
// out_o carries result words (channel reports or failure reports), cfg_i
// writes the fail limit and is always ready. All are valid/ready.
// An event passes an input stage and a short queue before the parser, and
// a failure word is then registered in the result register. The parser
// handles one event per cycle while no dump runs and its result word is
// not stalled. A good frame's closing checksum byte starts a dump of
// CHANNEL_SLOTS channel words, one per cycle while the receiver takes them;
// during the dump no further events are taken; these buffer in the queue.
// A failure gives one word. Events that give no word leave nothing behind.
// Reset clears the channel store and counters, sets the fail limit to 3 and
// puts the parser in the wait-for-gap phase.
// When the receiver stalls, the result word is held and the parser stops;
// the queue and input stage then fill, and in_i.ready drops.
// After the fail limit is reached all events are taken and dropped.
// ----------------------------------------------------------------------------
module ibus_frame_parser
  import ibfp_pkg::*;
#(
  parameter int unsigned CHANNEL_SLOTS = CHANNEL_SLOTS_DEF,
  parameter int unsigned QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ibfp_in_if.sink    in_i,
  ibfp_cfg_if.sink   cfg_i,
  ibfp_out_if.source out_o
);

  logic   push, push_ready, pop_valid, pop;
  entry_t push_entry, pop_entry;

  ibfp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_o       (push),
    .push_entry_o (push_entry),
    .push_ready_i (push_ready)
  );

  ibfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_entry_o  (pop_entry),
    .pop_i        (pop)
  );

  ibfp_back #(
    .CHANNEL_SLOTS (CHANNEL_SLOTS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (pop_valid),
    .op_entry_i (pop_entry),
    .op_pop_o   (pop),
    .cfg_i      (cfg_i),
    .out_o      (out_o)
  );

endmodule

// ===== tb/ibus_frame_parser_tb.sv =====
// ----------------------------------------------------------------------------
// ibus_frame_parser_tb
// Self-checking bench for the frame parser. Drives byte, gap and timeout
// events, predicts channel dumps and failure reports, and checks every
// result word in order.
// ----------------------------------------------------------------------------
import ibfp_pkg::*;

typedef struct packed {
  logic        kind;
  logic [4:0]  chan;
  logic [11:0] value;
  logic [3:0]  fail_count;
  logic        stopped;
  logic        last;
} parse_result_t;

typedef enum logic [1:0] {
  PH_WAIT_GAP,
  PH_WAIT_LEN,
  PH_BODY,
  PH_HALTED
} parse_phase_e;

typedef struct packed {
  parse_phase_e                           phase;
  logic [7:0]                             frame_len;
  logic [7:0]                             pos;
  logic [15:0]                            sum;
  logic [7:0]                             low_byte;
  logic                                   cmd_ok;
  logic [3:0]                             fails;
  logic [CHANNEL_SLOTS_DEF-1:0][11:0]     chans;
} parser_state_t;

class frame_scoreboard;
  parser_state_t st;
  logic [3:0]    fail_limit;
  parse_result_t pending_q[$];
  int unsigned   errors;

  function new();
    st         = '0;
    fail_limit = FAIL_LIMIT_RST;
    errors     = 0;
  endfunction

  function int unsigned limit_eff();
    return (fail_limit == 4'd0) ? 1 : int'(fail_limit);
  endfunction

  // Next parser state and the result words caused by one event.
  function void advance(input parser_state_t cur, input logic [1:0] req,
                        input logic [7:0] data, output parser_state_t nxt,
                        output parse_result_t words[$]);
    int unsigned p;
    int unsigned ch;
    logic        failed;
    nxt    = cur;
    words  = {};
    failed = 1'b0;
    p      = cur.pos;
    if (cur.phase == PH_HALTED || req == REQ_NONE) return;
    case (req)
      REQ_TIMEOUT: failed = 1'b1;
      REQ_GAP: begin
        if (cur.phase == PH_WAIT_GAP) nxt.phase = PH_WAIT_LEN;
      end
      default: begin
        if (cur.phase == PH_WAIT_LEN) begin
          if (data <= MIN_LEN || data[0]) begin
            failed = 1'b1;
          end else begin
            nxt.frame_len = data;
            nxt.pos       = 8'd0;
            nxt.sum       = SUM_INIT - data;
            nxt.low_byte  = 8'd0;
            nxt.cmd_ok    = 1'b0;
            nxt.phase     = PH_BODY;
          end
        end else if (cur.phase == PH_BODY) begin
          if (p + 2 == cur.frame_len) begin
            if (!cur.cmd_ok || {data, cur.low_byte} != cur.sum) begin
              failed = 1'b1;
            end else begin
              nxt.fails = 4'd0;
              nxt.phase = PH_WAIT_LEN;
              for (int k = 0; k < CHANNEL_SLOTS_DEF; k++) begin
                words.push_back(parse_result_t'{kind: KIND_CHANNEL, chan: 5'(k),
                  value: cur.chans[k], fail_count: 4'd0, stopped: 1'b0,
                  last: (k == CHANNEL_SLOTS_DEF - 1)});
              end
            end
          end else begin
            if (p == 0) begin
              nxt.cmd_ok = (data == CMD_BYTE);
              nxt.sum    = cur.sum - data;
            end else if (p + 3 == cur.frame_len) begin
              // checksum low byte: held, not summed
              nxt.low_byte = data;
            end else if (p[0]) begin
              nxt.low_byte = data;
              nxt.sum      = cur.sum - data;
            end else begin
              ch = (p - 2) >> 1;
              if (cur.cmd_ok && ch < CHANNEL_SLOTS_DEF)
                nxt.chans[ch] = {data[3:0], cur.low_byte};
              nxt.sum = cur.sum - data;
            end
            nxt.pos = cur.pos + 8'd1;
          end
        end
      end
    endcase
    if (failed) begin
      if (cur.fails != FAIL_COUNT_MAX) nxt.fails = cur.fails + 4'd1;
      nxt.phase = (nxt.fails >= limit_eff()) ? PH_HALTED : PH_WAIT_GAP;
      words.push_back(parse_result_t'{kind: KIND_FAIL, chan: 5'd0, value: 12'd0,
        fail_count: nxt.fails, stopped: (nxt.phase == PH_HALTED), last: 1'b1});
    end
  endfunction

  function void note_event(logic [1:0] req, logic [7:0] data);
    parser_state_t nxt;
    parse_result_t words[$];
    advance(st, req, data, nxt, words);
    st = nxt;
    foreach (words[i]) pending_q.push_back(words[i]);
  endfunction

  // Failure count the parser would hold after this event.
  function int unsigned fails_after(logic [1:0] req, logic [7:0] data);
    parser_state_t nxt;
    parse_result_t words[$];
    advance(st, req, data, nxt, words);
    return nxt.fails;
  endfunction

  function void report(string field, logic [11:0] want, logic [11:0] got);
    errors++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
  endfunction

  function void check_word(parse_result_t got);
    parse_result_t want;
    if (pending_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected word, expected none, got kind %0d index %0d value %0d",
               $time, got.kind, got.chan, got.value);
      return;
    end
    want = pending_q.pop_front();
    if (got.kind !== want.kind) report("kind", want.kind, got.kind);
    if (got.chan !== want.chan) report("channel_index", want.chan, got.chan);
    if (got.value !== want.value) report("channel_value", want.value, got.value);
    if (got.fail_count !== want.fail_count)
      report("fail_count", want.fail_count, got.fail_count);
    if (got.stopped !== want.stopped) report("stopped", want.stopped, got.stopped);
    if (got.last !== want.last) report("last", want.last, got.last);
  endfunction
endclass

module ibus_frame_parser_tb;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned RUN_LIMIT    = 1_000_000;

  logic clk = 1'b0;
  logic rst_n;

  int unsigned src_idle_pct = 10;
  int unsigned snk_idle_pct = 56;
  int unsigned events_sent  = 0;

  frame_scoreboard parse_sb;

  ibfp_in_if  in_bus ();
  ibfp_out_if res_bus ();
  ibfp_cfg_if cfg_bus ();

  ibus_frame_parser u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .cfg_i  (cfg_bus),
    .out_o  (res_bus)
  );

  always #1 clk = ~clk;

  task automatic send_event(input logic [1:0] req, input logic [7:0] data);
    while ($urandom_range(99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.req_type  <= req;
    in_bus.data_byte <= data;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    parse_sb.note_event(req, data);
    if (req != REQ_NONE) events_sent++;
  endtask

  // fill < 0 gives random channel bytes; cut > 0 sends only the first bytes
  task automatic send_frame(input int unsigned len, input logic [7:0] cmd, input int fill,
                            input bit bad_sum, input int unsigned cut);
    logic [7:0]  frame_q[$];
    logic [15:0] sum;
    logic [7:0]  b;
    int unsigned n;
    sum = SUM_INIT - 16'(len);
    frame_q.push_back(8'(len));
    frame_q.push_back(cmd);
    sum = sum - cmd;
    for (int i = 0; i < int'(len) - 4; i++) begin
      b = (fill < 0) ? 8'($urandom) : 8'(fill);
      frame_q.push_back(b);
      sum = sum - b;
    end
    if (bad_sum) sum = sum ^ (16'd1 << $urandom_range(15));
    frame_q.push_back(sum[7:0]);
    frame_q.push_back(sum[15:8]);
    n = (cut == 0) ? frame_q.size() : cut;
    for (int i = 0; i < int'(n); i++) send_event(REQ_BYTE, frame_q[i]);
  endtask

  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    while (parse_sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_fail_limit(input logic [3:0] lim);
    cfg_bus.valid      <= 1'b1;
    cfg_bus.fail_limit <= lim;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    parse_sb.fail_limit = lim;
  endtask

  task automatic random_sequence();
    int unsigned pick;
    int unsigned len;
    int unsigned lim;
    int unsigned nf;
    int          fill;
    logic [7:0]  cmd;
    logic [1:0]  req;
    logic [7:0]  data;
    bit          risky_ok;
    bit          noise_ok;
    lim      = parse_sb.limit_eff();
    risky_ok = parse_sb.st.fails + 1 < lim;
    noise_ok = parse_sb.st.fails + 3 <= lim;
    pick     = $urandom_range(99);
    if (pick >= 50 && !risky_ok) pick = 0;
    if (pick >= 90 && !noise_ok) pick = 80;
    len  = ($urandom_range(9) == 0) ? 2 * $urandom_range(2, 127) : 2 * $urandom_range(2, 18);
    case ($urandom_range(7))
      0:       fill = 8'hFF;
      1:       fill = 8'h00;
      default: fill = -1;
    endcase
    if (pick < 80 && parse_sb.st.phase == PH_WAIT_GAP) send_event(REQ_GAP, 8'($urandom));
    if (pick < 50) begin
      send_frame(len, CMD_BYTE, fill, 1'b0, 0);
    end else if (pick < 60) begin
      send_frame(len, CMD_BYTE, fill, 1'b1, 0);
    end else if (pick < 68) begin
      do cmd = 8'($urandom); while (cmd == CMD_BYTE);
      send_frame(len, cmd, fill, $urandom_range(1), 0);
    end else if (pick < 74) begin
      send_frame(len, CMD_BYTE, fill, 1'b0, $urandom_range(1, len - 1));
      send_event(REQ_TIMEOUT, 8'($urandom));
    end else if (pick < 80) begin
      // odd, or even but too short
      send_event(REQ_BYTE, $urandom_range(1) ? 8'($urandom | 1) : 8'(2 * $urandom_range(1)));
    end else if (pick < 90) begin
      case ($urandom_range(2))
        0:       send_event(REQ_TIMEOUT, 8'($urandom));
        1:       send_event(REQ_GAP, 8'($urandom));
        default: send_event(REQ_NONE, 8'($urandom));
      endcase
    end else begin
      // noise that never brings the count to the limit; a timeout resyncs
      repeat ($urandom_range(1, 6)) begin
        req  = 2'($urandom_range(3));
        data = 8'($urandom);
        nf   = parse_sb.fails_after(req, data);
        if (nf > parse_sb.st.fails && nf + 1 >= lim) req = REQ_NONE;
        send_event(req, data);
      end
      if (parse_sb.st.phase == PH_BODY) send_event(REQ_TIMEOUT, 8'($urandom));
    end
  endtask

  // result side: check accepted words, stall at random
  initial begin
    res_bus.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (res_bus.valid && res_bus.ready)
        parse_sb.check_word(parse_result_t'{kind: res_bus.kind,
          chan: res_bus.channel_index, value: res_bus.channel_value,
          fail_count: res_bus.fail_count, stopped: res_bus.stopped,
          last: res_bus.last});
      res_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  initial begin
    logic [3:0]  limit_plan [5];
    int unsigned phase_end;
    in_bus.valid       <= 1'b0;
    in_bus.req_type    <= REQ_NONE;
    in_bus.data_byte   <= 8'd0;
    cfg_bus.valid      <= 1'b0;
    cfg_bus.fail_limit <= FAIL_LIMIT_RST;
    rst_n              <= 1'b0;
    parse_sb = new();
    limit_plan = '{4'd15, 4'd1, 4'd2, 4'($urandom_range(3, 14)), 4'd15};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset fail limit of 3
    send_event(REQ_BYTE, 8'hFF);
    send_event(REQ_TIMEOUT, 8'h00);
    send_event(REQ_NONE, 8'hA5);
    send_event(REQ_GAP, 8'h5A);
    send_event(REQ_GAP, 8'h00);
    send_event(REQ_BYTE, 8'h05);
    send_event(REQ_GAP, 8'h00);
    // shortest frame, gap inside the body is ignored
    send_event(REQ_BYTE, 8'h04);
    send_event(REQ_BYTE, CMD_BYTE);
    send_event(REQ_GAP, 8'h00);
    send_event(REQ_BYTE, 8'hBB);
    send_event(REQ_BYTE, 8'hFF);
    // bad checksum still stores the all-ones channel
    send_frame(6, CMD_BYTE, 8'hFF, 1'b1, 0);
    send_event(REQ_GAP, 8'h00);
    send_frame(4, 8'hBF, -1, 1'b0, 0);
    send_event(REQ_GAP, 8'h00);
    send_frame(4, CMD_BYTE, -1, 1'b0, 0);

    foreach (limit_plan[i]) begin
      wait_idle();
      write_fail_limit(limit_plan[i]);
      if (limit_plan[i] == 4'd15)
        while (parse_sb.st.fails < 4'd14) send_event(REQ_TIMEOUT, 8'($urandom));
      phase_end = events_sent + 100;
      while (events_sent < phase_end) begin
        if (events_sent < 200) begin
          src_idle_pct = 10;
          snk_idle_pct = 56;
        end else if (events_sent < 370) begin
          src_idle_pct = 56;
          snk_idle_pct = 10;
        end else begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
        random_sequence();
      end
    end

    // zero limit acts as one: next failure halts, then all is dropped
    wait_idle();
    write_fail_limit(4'd0);
    send_event(REQ_TIMEOUT, 8'($urandom));
    send_event(REQ_GAP, 8'h00);
    send_event(REQ_BYTE, 8'h04);
    send_event(REQ_TIMEOUT, 8'h00);
    wait_idle();

    if (parse_sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #RUN_LIMIT;
    $display("TEST FAILED");
    $finish;
  end
endmodule

// ===== sim.f =====
design/ibfp_pkg.sv
design/ibfp_if.sv
design/ibfp_front.sv
design/ibfp_queue.sv
design/ibfp_back.sv
design/ibus_frame_parser.sv
tb/ibus_frame_parser_tb.sv
